// ===== sv/wscfm_pkg.sv =====
// Shared widths, constants and types of the WebSocket client frame masker.
`timescale 1ns / 1ps

package wscfm_pkg;

   localparam int OP_W   = 4;
   localparam int LEN_W  = 63;
   localparam int KEY_W  = 32;
   localparam int BYTE_W = 8;

   localparam int REQ_FIELD_W = OP_W + LEN_W + KEY_W + BYTE_W;
   localparam int REQ_TDATA_W = ((REQ_FIELD_W + 7) / 8) * 8;

   localparam int OP_LSB   = 0;
   localparam int LEN_LSB  = OP_LSB + OP_W;
   localparam int KEY_LSB  = LEN_LSB + LEN_W;
   localparam int DATA_LSB = KEY_LSB + KEY_W;

   localparam int HDR_REST_BYTES = 13;
   localparam int HDR_REST_W     = HDR_REST_BYTES * BYTE_W;
   localparam int HDR_CNT_W      = 4;

   localparam logic [BYTE_W-1:0] MASKED_FLAG  = 8'h80;
   localparam logic [BYTE_W-1:0] LEN_CODE_16  = 8'd126;
   localparam logic [BYTE_W-1:0] LEN_CODE_64  = 8'd127;
   localparam logic [LEN_W-1:0]  LEN_MAX_16   = 63'h0000_0000_0000_FFFF;

   localparam logic [HDR_CNT_W-1:0] HDR_REST_SHORT = 4'd5;
   localparam logic [HDR_CNT_W-1:0] HDR_REST_MID   = 4'd7;
   localparam logic [HDR_CNT_W-1:0] HDR_REST_LONG  = 4'd13;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_DATA  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic [HDR_REST_W-1:0] rest;
      logic [HDR_CNT_W-1:0]  count;
      logic                  empty_frame;
   } hdr_type;

endpackage

// ===== sv/websocket_client_frame_masker_core.sv =====
// Top level of the WebSocket client frame masker: input register, header serialiser, masker.
// An accepted transaction passes through the input register and then the output register.
// Throughput: one payload byte per cycle while the output is ready; a start transaction sends
// 6, 8 or 14 header bytes (short, 16-bit and 64-bit lengths) and holds the input meanwhile.
// The header shift register drains one byte a cycle (output ready) before the next transaction.
// Reset: synchronous, active high; clears handshake state, frame state and the header count.
`timescale 1ns / 1ps

module websocket_client_frame_masker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // opcode[3:0], frame_length[66:4], masking_key[98:67], data_byte[106:99], zero pad
   input  logic [wscfm_pkg::REQ_TDATA_W-1:0] req_tdata,
   // cmd[0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_byte[7:0]
   output logic [wscfm_pkg::BYTE_W-1:0]      rsp_tdata,
   // is_header[0]
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   logic                           in_valid_ff, in_valid_in;
   wscfm_pkg::cmd_type             in_cmd_ff;
   logic [wscfm_pkg::OP_W-1:0]     in_opcode_ff;
   logic [wscfm_pkg::LEN_W-1:0]    in_len_ff;
   logic [wscfm_pkg::KEY_W-1:0]    in_key_ff;
   logic [wscfm_pkg::BYTE_W-1:0]   in_data_ff;

   logic [wscfm_pkg::HDR_REST_W-1:0] hdr_ff, hdr_in;
   logic [wscfm_pkg::HDR_CNT_W-1:0]  hdr_left_ff, hdr_left_in;
   logic                             hdr_end_ff, hdr_end_in;

   logic                           in_frame_ff, in_frame_in;
   logic [wscfm_pkg::LEN_W-1:0]    bytes_left_ff, bytes_left_in;
   logic [wscfm_pkg::KEY_W-1:0]    held_key_ff, held_key_in;
   logic [1:0]                     key_pos_ff, key_pos_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [wscfm_pkg::BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                           rsp_user_ff, rsp_user_in;
   logic                           rsp_last_ff, rsp_last_in;

   wscfm_pkg::hdr_type             hdr_built;
   logic                           out_free;
   logic                           hdr_busy;
   logic                           in_take;
   logic [wscfm_pkg::BYTE_W-1:0]   key_byte;
   logic                           last_payload;

   wscfm_header u_header (
      .frame_length (in_len_ff),
      .key_word     (in_key_ff),
      .hdr          (hdr_built)
   );

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign hdr_busy     = (hdr_left_ff != '0);
   assign in_take      = in_valid_ff && !hdr_busy && out_free;
   assign req_tready   = !in_valid_ff || in_take;
   assign key_byte     = held_key_ff[{~key_pos_ff, 3'b000} +: 8];
   assign last_payload = (bytes_left_ff == wscfm_pkg::LEN_W'(1));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      in_valid_in   = in_valid_ff;
      hdr_in        = hdr_ff;
      hdr_left_in   = hdr_left_ff;
      hdr_end_in    = hdr_end_ff;
      in_frame_in   = in_frame_ff;
      bytes_left_in = bytes_left_ff;
      held_key_in   = held_key_ff;
      key_pos_in    = key_pos_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      rsp_last_in   = rsp_last_ff;

      if (req_tready) begin
         in_valid_in = req_tvalid;
      end

      if (hdr_busy && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = hdr_ff[wscfm_pkg::BYTE_W-1:0];
         rsp_user_in  = 1'b1;
         rsp_last_in  = (hdr_left_ff == wscfm_pkg::HDR_CNT_W'(1)) && hdr_end_ff;
         hdr_in       = hdr_ff >> wscfm_pkg::BYTE_W;
         hdr_left_in  = hdr_left_ff - wscfm_pkg::HDR_CNT_W'(1);
      end else if (in_take) begin
         if (in_cmd_ff == wscfm_pkg::CMD_START) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = wscfm_pkg::MASKED_FLAG | {4'd0, in_opcode_ff};
            rsp_user_in   = 1'b1;
            rsp_last_in   = 1'b0;
            hdr_in        = hdr_built.rest;
            hdr_left_in   = hdr_built.count;
            hdr_end_in    = hdr_built.empty_frame;
            held_key_in   = in_key_ff;
            key_pos_in    = 2'd0;
            bytes_left_in = in_len_ff;
            in_frame_in   = !hdr_built.empty_frame;
         end else if (in_frame_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = in_data_ff ^ key_byte;
            rsp_user_in   = 1'b0;
            rsp_last_in   = last_payload;
            bytes_left_in = bytes_left_ff - wscfm_pkg::LEN_W'(1);
            key_pos_in    = key_pos_ff + 2'd1;
            in_frame_in   = !last_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         hdr_left_ff   <= '0;
         hdr_end_ff    <= 1'b0;
         in_frame_ff   <= 1'b0;
         bytes_left_ff <= '0;
         held_key_ff   <= '0;
         key_pos_ff    <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         hdr_left_ff   <= hdr_left_in;
         hdr_end_ff    <= hdr_end_in;
         in_frame_ff   <= in_frame_in;
         bytes_left_ff <= bytes_left_in;
         held_key_ff   <= held_key_in;
         key_pos_ff    <= key_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
      if (req_tvalid && req_tready) begin
         in_cmd_ff    <= wscfm_pkg::cmd_type'(req_tuser);
         in_opcode_ff <= req_tdata[wscfm_pkg::OP_LSB +: wscfm_pkg::OP_W];
         in_len_ff    <= req_tdata[wscfm_pkg::LEN_LSB +: wscfm_pkg::LEN_W];
         in_key_ff    <= req_tdata[wscfm_pkg::KEY_LSB +: wscfm_pkg::KEY_W];
         in_data_ff   <= req_tdata[wscfm_pkg::DATA_LSB +: wscfm_pkg::BYTE_W];
      end
   end

endmodule

// ===== sv/wscfm_header.sv =====
// Header byte builder: length code, extended length and key bytes after the first byte.
`timescale 1ns / 1ps

module wscfm_header (
   input  logic [wscfm_pkg::LEN_W-1:0] frame_length,
   input  logic [wscfm_pkg::KEY_W-1:0] key_word,
   output wscfm_pkg::hdr_type          hdr
);

   logic [wscfm_pkg::KEY_W-1:0]    key_rev;
   logic [2*wscfm_pkg::BYTE_W-1:0] len16_rev;
   logic [8*wscfm_pkg::BYTE_W-1:0] len64;
   logic [8*wscfm_pkg::BYTE_W-1:0] len64_rev;
   logic [wscfm_pkg::BYTE_W-1:0]   short_code;

   always_comb begin
      len64 = {1'b0, frame_length};
      for (int i = 0; i < 4; i++) begin
         key_rev[i*8 +: 8] = key_word[(3-i)*8 +: 8];
      end
      for (int i = 0; i < 8; i++) begin
         len64_rev[i*8 +: 8] = len64[(7-i)*8 +: 8];
      end
      len16_rev  = {frame_length[7:0], frame_length[15:8]};
      short_code = wscfm_pkg::MASKED_FLAG | {1'b0, frame_length[6:0]};

      hdr.empty_frame = (frame_length == '0);
      if (frame_length < wscfm_pkg::LEN_W'(wscfm_pkg::LEN_CODE_16)) begin
         hdr.rest  = {64'd0, key_rev, short_code};
         hdr.count = wscfm_pkg::HDR_REST_SHORT;
      end else if (frame_length <= wscfm_pkg::LEN_MAX_16) begin
         hdr.rest  = {48'd0, key_rev, len16_rev,
                      wscfm_pkg::MASKED_FLAG | wscfm_pkg::LEN_CODE_16};
         hdr.count = wscfm_pkg::HDR_REST_MID;
      end else begin
         hdr.rest  = {key_rev, len64_rev, wscfm_pkg::MASKED_FLAG | wscfm_pkg::LEN_CODE_64};
         hdr.count = wscfm_pkg::HDR_REST_LONG;
      end
   end

endmodule

// ===== tb/websocket_client_frame_masker_core_tb.sv =====
// Self-checking testbench for the WebSocket client frame masker: header, key and masked payload bytes.
`timescale 1ns / 1ps

module websocket_client_frame_masker_core_tb;

   localparam int ITEM_TARGET   = 380;
   localparam int QUIET_TAIL    = 320;
   localparam int HOLD_CYCLES   = 400;
   localparam int STALL_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 20;

   typedef struct packed {
      logic [wscfm_pkg::BYTE_W-1:0] value;
      logic                         header;
      logic                         last;
   } wire_byte_type;

   class frame_scoreboard;
      wire_byte_type                wire_q[$];
      bit                           frame_open;
      logic [wscfm_pkg::LEN_W-1:0]  payload_left;
      logic [wscfm_pkg::KEY_W-1:0]  frame_key;
      logic [1:0]                   key_slot;
      int                           errors;
      int                           starts;
      int                           masked;
      int                           checked;

      function void push_byte(logic [wscfm_pkg::BYTE_W-1:0] v, logic h, logic l);
         wire_q.push_back('{value: v, header: h, last: l});
      endfunction

      // Work out the wire bytes that one accepted transaction produces.
      function void note_transaction(wscfm_pkg::cmd_type c, logic [wscfm_pkg::OP_W-1:0] op,
                                     logic [wscfm_pkg::LEN_W-1:0] len,
                                     logic [wscfm_pkg::KEY_W-1:0] k,
                                     logic [wscfm_pkg::BYTE_W-1:0] d);
         logic [wscfm_pkg::BYTE_W-1:0] kb;
         logic [63:0]                  len64;
         int                           i;
         if (c == wscfm_pkg::CMD_START) begin
            starts++;
            len64 = {1'b0, len};
            push_byte(wscfm_pkg::MASKED_FLAG | {4'b0, op}, 1'b1, 1'b0);
            if (len < wscfm_pkg::LEN_W'(wscfm_pkg::LEN_CODE_16)) begin
               push_byte(wscfm_pkg::MASKED_FLAG | len[7:0], 1'b1, 1'b0);
            end else if (len <= wscfm_pkg::LEN_MAX_16) begin
               push_byte(wscfm_pkg::MASKED_FLAG | wscfm_pkg::LEN_CODE_16, 1'b1, 1'b0);
               push_byte(len[15:8], 1'b1, 1'b0);
               push_byte(len[7:0], 1'b1, 1'b0);
            end else begin
               push_byte(wscfm_pkg::MASKED_FLAG | wscfm_pkg::LEN_CODE_64, 1'b1, 1'b0);
               for (i = 7; i >= 0; i--)
                  push_byte(len64[8*i +: 8], 1'b1, 1'b0);
            end
            for (i = 3; i >= 0; i--)
               push_byte(k[8*i +: 8], 1'b1, (i == 0) && (len == '0));
            frame_key    = k;
            key_slot     = 2'd0;
            payload_left = len;
            frame_open   = (len != '0);
         end else if (frame_open) begin
            masked++;
            kb           = frame_key[8*(3-key_slot) +: 8];
            payload_left = payload_left - 1'b1;
            push_byte(d ^ kb, 1'b0, payload_left == '0);
            key_slot     = key_slot + 2'd1;
            if (payload_left == '0)
               frame_open = 1'b0;
         end
      endfunction

      function void check_result(logic [wscfm_pkg::BYTE_W-1:0] v, logic h, logic l);
         wire_byte_type want;
         checked++;
         if (wire_q.size() == 0) begin
            $error("out_byte %02h arrived with nothing expected", v);
            errors++;
            return;
         end
         want = wire_q.pop_front();
         if (want.value !== v) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.value, v);
            errors++;
         end
         if (want.header !== h) begin
            $error("is_header mismatch: expected %0b, actual %0b", want.header, h);
            errors++;
         end
         if (want.last !== l) begin
            $error("frame_end mismatch: expected %0b, actual %0b", want.last, l);
            errors++;
         end
      endfunction
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [wscfm_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                              req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [wscfm_pkg::BYTE_W-1:0]      rsp_tdata;
   logic                              rsp_tuser;
   logic                              rsp_tlast;

   frame_scoreboard sb = new();

   int                          counted;
   logic [wscfm_pkg::LEN_W-1:0] open_left;
   bit                          idle_on;
   bit                          hold_request;
   bit                          hold_fired;
   int                          quiet_cycles;

   websocket_client_frame_masker_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_transaction(wscfm_pkg::cmd_type'(req_tuser),
                                req_tdata[wscfm_pkg::OP_LSB +: wscfm_pkg::OP_W],
                                req_tdata[wscfm_pkg::LEN_LSB +: wscfm_pkg::LEN_W],
                                req_tdata[wscfm_pkg::KEY_LSB +: wscfm_pkg::KEY_W],
                                req_tdata[wscfm_pkg::DATA_LSB +: wscfm_pkg::BYTE_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("Timed out after %0d cycles without a transaction", quiet_cycles);
               $display("websocket_client_frame_masker_core_tb: errors");
               $finish;
            end
         end
      end
   end

   // Receiver: random stalls, one long hold-off on request.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic drive_item(wscfm_pkg::cmd_type c, logic [wscfm_pkg::OP_W-1:0] op,
                             logic [wscfm_pkg::LEN_W-1:0] len,
                             logic [wscfm_pkg::KEY_W-1:0] k,
                             logic [wscfm_pkg::BYTE_W-1:0] d);
      logic [wscfm_pkg::REQ_TDATA_W-1:0] word;
      word = '0;
      word[wscfm_pkg::OP_LSB +: wscfm_pkg::OP_W]     = op;
      word[wscfm_pkg::LEN_LSB +: wscfm_pkg::LEN_W]   = len;
      word[wscfm_pkg::KEY_LSB +: wscfm_pkg::KEY_W]   = k;
      word[wscfm_pkg::DATA_LSB +: wscfm_pkg::BYTE_W] = d;
      idle_on = (counted < QUIET_TAIL) && ((counted / 50) % 3 != 1);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (c == wscfm_pkg::CMD_START) begin
         open_left = len;
         counted++;
      end else if (open_left != '0) begin
         open_left--;
         counted++;
      end
   endtask

   task automatic start_frame(logic [wscfm_pkg::OP_W-1:0] op, logic [wscfm_pkg::LEN_W-1:0] len,
                              logic [wscfm_pkg::KEY_W-1:0] k);
      drive_item(wscfm_pkg::CMD_START, op, len, k, wscfm_pkg::BYTE_W'($urandom));
   endtask

   task automatic send_payload(logic [wscfm_pkg::BYTE_W-1:0] d);
      drive_item(wscfm_pkg::CMD_DATA, wscfm_pkg::OP_W'($urandom),
                 wscfm_pkg::LEN_W'({$urandom, $urandom}), $urandom, d);
   endtask

   initial begin
      int                          pick;
      int                          n;
      logic [wscfm_pkg::LEN_W-1:0] len;

      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tuser    <= 1'b0;
      req_tdata    <= '0;
      counted      = 0;
      open_left    = '0;
      idle_on      = 1'b1;
      hold_request = 1'b0;
      hold_fired   = 1'b0;
      quiet_cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: payload outside a frame, empty frame, all length classes, restarts.
      send_payload(8'hFF);
      start_frame(4'd0, '0, 32'h0000_0000);
      start_frame(4'd15, 63'd1, 32'hFFFF_FFFF);
      send_payload(8'h00);
      start_frame(4'd1, 63'd5, 32'h1234_5678);
      repeat (5) send_payload(wscfm_pkg::BYTE_W'($urandom));
      send_payload(8'hA5);
      start_frame(4'd10, 63'd125, 32'hDEAD_BEEF);
      send_payload(8'hFF);
      send_payload(8'h00);
      start_frame(4'd2, 63'd126, 32'hA5A5_5A5A);
      send_payload(8'h3C);
      start_frame(4'd9, 63'd65535, $urandom);
      start_frame(4'd8, 63'd65536, $urandom);
      send_payload(8'h81);
      start_frame(4'd2, {wscfm_pkg::LEN_W{1'b1}}, $urandom);
      send_payload(8'h7E);
      send_payload(8'hC3);
      start_frame(4'd3, 63'd3, $urandom);
      repeat (3) send_payload(wscfm_pkg::BYTE_W'($urandom));

      while (counted < ITEM_TARGET) begin
         if (!hold_fired && counted >= 150) begin
            hold_request = 1'b1;
            hold_fired   = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(126, 140) : $urandom_range(0, 12);
            start_frame(wscfm_pkg::OP_W'($urandom), wscfm_pkg::LEN_W'(n), $urandom);
            repeat (n) send_payload(wscfm_pkg::BYTE_W'($urandom));
         end else if (pick < 85) begin
            case ($urandom_range(0, 2))
               0:       len = wscfm_pkg::LEN_W'($urandom_range(1, 125));
               1:       len = wscfm_pkg::LEN_W'($urandom_range(126, 65535));
               default: len = wscfm_pkg::LEN_W'({$urandom, $urandom});
            endcase
            if (len == '0)
               len = 63'd1;
            start_frame(wscfm_pkg::OP_W'($urandom), len, $urandom);
            n = $urandom_range(0, 6);
            if (len <= wscfm_pkg::LEN_W'(n))
               n = int'(len) - 1;
            repeat (n) send_payload(wscfm_pkg::BYTE_W'($urandom));
         end else if (pick < 95) begin
            repeat ($urandom_range(1, 3)) send_payload(wscfm_pkg::BYTE_W'($urandom));
         end else begin
            start_frame(wscfm_pkg::OP_W'($urandom), '0, $urandom);
         end
      end
      req_tvalid <= 1'b0;

      while (sb.wire_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d frame starts, %0d masked payload bytes, %0d wire bytes checked,",
               sb.starts, sb.masked, sb.checked);
      $display("including every length class, abandoned frames, stray bytes and a long output hold.");
      if (sb.errors == 0) begin
         $display("websocket_client_frame_masker_core_tb: clean");
      end else begin
         $display("websocket_client_frame_masker_core_tb: errors");
      end
      $finish;
   end

endmodule
